### rtl/led_blink_pattern_sequencer_top_macros.svh
// Assertion macros used by the LED blink sequencer checker.
// No dependencies; include with the bare file name.
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define LBPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define LBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lbps_pkg.sv
// Shared types, codes and the blink table of the LED blink sequencer.
// No dependencies.
package lbps_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int PHASE_BITS_DEF   = 20;
    localparam int CH_MAX           = 8;
    localparam int PAT_W            = 3;
    localparam int COLOUR_W         = 24;

    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_SET_PATTERN = 3'd1;
    localparam logic [2:0] CMD_ONESHOT     = 3'd2;
    localparam logic [2:0] CMD_SET_COLOUR  = 3'd3;
    localparam logic [2:0] CMD_SET_STANDBY = 3'd4;

    localparam logic [7:0]          ENABLE_RESET = 8'h01;
    localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 24'hFFFFFF;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

    typedef struct packed {
        logic [2:0] channel;
        logic       lit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } result_t;

    // Indices 6 and 7 have no table word and read as off.
    function automatic logic [31:0] blink_word(input logic [2:0] pat);
        logic [31:0] w;
        case (pat)
            3'd0:    w = 32'h0000_0000;
            3'd1:    w = 32'h000F_FFFF;
            3'd2:    w = 32'h0000_0003;
            3'd3:    w = 32'h0003_FFFF;
            3'd4:    w = 32'h0005_5555;
            3'd5:    w = 32'h0000_7C1F;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

### rtl/lbps_state_mem.sv
// Per-channel state memory: one write port, one registered read port.
// Depends on lbps_pkg.
module lbps_state_mem #(
    parameter int                 DEPTH      = lbps_pkg::CH_MAX,
    parameter int                 ADDR_W     = 3,
    parameter int                 WIDTH      = 74,
    parameter logic [WIDTH-1:0]   RESET_WORD = '0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lbps_pkg::mem_cmd_t   mem_cmd,
    input  logic [ADDR_W-1:0]    addr,
    input  logic [WIDTH-1:0]     wr_data,
    output logic [WIDTH-1:0]     rd_data
);
    import lbps_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    // Entries never written read as their reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_cmd.wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.wr_en) begin
            mem_reg[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.rd_en) begin
            rd_data_reg <= valid_reg[addr] ? mem_reg[addr] : RESET_WORD;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lbps_ctrl.sv
// Sequencer: read-modify-write of channel state for requests and ticks.
// Depends on lbps_pkg; drives lbps_state_mem.
module lbps_ctrl #(
    parameter int CH_LIMIT   = lbps_pkg::CH_MAX,
    parameter int ADDR_W     = 3,
    parameter int PHASE_BITS = lbps_pkg::PHASE_BITS_DEF,
    parameter int WORD_W     = 74
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           channel_enable,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_cmd,
    input  logic [2:0]           s_channel,
    input  logic [2:0]           s_pattern,
    input  logic [4:0]           s_cycle,
    input  logic [23:0]          s_rgb,
    output lbps_pkg::mem_cmd_t   mem_cmd,
    output logic [ADDR_W-1:0]    mem_addr,
    output logic [WORD_W-1:0]    mem_wr_data,
    input  logic [WORD_W-1:0]    mem_rd_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lbps_pkg::result_t    res
);
    import lbps_pkg::*;

    localparam int SB_LSB = 0;
    localparam int CL_LSB = COLOUR_W;
    localparam int PH_LSB = 2 * COLOUR_W;
    localparam int OS_LSB = PH_LSB + PHASE_BITS;
    localparam int ST_LSB = OS_LSB + PAT_W;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1);
    localparam logic [PHASE_BITS-1:0] PHASE_TOP = PHASE_ONE << (PHASE_BITS - 1);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(CH_LIMIT - 1);
    localparam logic [7:0]            LIMIT_MASK = 8'((9'd1 << CH_LIMIT) - 9'd1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [2:0]        pat_reg, pat_next;
    logic [4:0]        cyc_reg, cyc_next;
    logic [23:0]       rgb_reg, rgb_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic                  is_tick;
    logic                  known_req;
    logic                  in_range;
    logic [2:0]            steady;
    logic [2:0]            oneshot;
    logic [PHASE_BITS-1:0] phase;
    logic [23:0]           colour;
    logic [23:0]           standby;
    logic [2:0]            pick;
    logic [31:0]           word;
    logic                  lit;
    logic [4:0]            cyc_sat;
    logic [7:0]            above;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        pat_reg  <= pat_next;
        cyc_reg  <= cyc_next;
        rgb_reg  <= rgb_next;
        addr_reg <= addr_next;
    end

    // Field view of the entry just read.
    always_comb begin
        standby = mem_rd_data[SB_LSB +: COLOUR_W];
        colour  = mem_rd_data[CL_LSB +: COLOUR_W];
        phase   = mem_rd_data[PH_LSB +: PHASE_BITS];
        oneshot = mem_rd_data[OS_LSB +: PAT_W];
        steady  = mem_rd_data[ST_LSB +: PAT_W];
        pick    = (oneshot != 3'd0) ? oneshot : steady;
        word    = blink_word(pick);
        lit     = |(word[PHASE_BITS-1:0] & phase);
        cyc_sat = ({1'b0, cyc_reg} > 6'(PHASE_BITS - 1)) ? 5'(PHASE_BITS - 1) : cyc_reg;
        above   = ~((8'd2 << 3'(addr_reg)) - 8'd1);
    end

    // Modified entry.
    always_comb begin
        mem_wr_data = mem_rd_data;
        case (cmd_reg)
            CMD_TICK: begin
                if (phase > PHASE_ONE) begin
                    mem_wr_data[PH_LSB +: PHASE_BITS] = phase >> 1;
                end else begin
                    mem_wr_data[PH_LSB +: PHASE_BITS] = PHASE_TOP;
                    mem_wr_data[OS_LSB +: PAT_W]      = 3'd0;
                end
            end
            CMD_SET_PATTERN: begin
                mem_wr_data[ST_LSB +: PAT_W] = pat_reg;
            end
            CMD_ONESHOT: begin
                mem_wr_data[OS_LSB +: PAT_W]      = pat_reg;
                mem_wr_data[PH_LSB +: PHASE_BITS] = PHASE_ONE << cyc_sat;
            end
            CMD_SET_COLOUR: begin
                mem_wr_data[CL_LSB +: COLOUR_W] = (rgb_reg != 24'd0) ? rgb_reg : standby;
            end
            CMD_SET_STANDBY: begin
                mem_wr_data[SB_LSB +: COLOUR_W] = rgb_reg;
            end
            default: begin
                mem_wr_data = mem_rd_data;
            end
        endcase
    end

    always_comb begin
        res.channel = 3'(addr_reg);
        res.lit     = lit;
        res.red     = lit ? colour[23:16] : 8'd0;
        res.green   = lit ? colour[15:8]  : 8'd0;
        res.blue    = lit ? colour[7:0]   : 8'd0;
        res.last    = (channel_enable & LIMIT_MASK & above) == 8'd0;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pat_next   = pat_reg;
        cyc_next   = cyc_reg;
        rgb_next   = rgb_reg;
        addr_next  = addr_reg;
        mem_cmd    = '0;
        res_valid  = 1'b0;
        s_ready    = (state_reg == ST_IDLE);
        is_tick    = (cmd_reg == CMD_TICK);
        known_req  = (s_cmd == CMD_SET_PATTERN) || (s_cmd == CMD_ONESHOT) ||
                     (s_cmd == CMD_SET_COLOUR) || (s_cmd == CMD_SET_STANDBY);
        in_range   = {1'b0, s_channel} < 4'(CH_LIMIT);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_cmd;
                    pat_next = s_pattern;
                    cyc_next = s_cycle;
                    rgb_next = s_rgb;
                    if (s_cmd == CMD_TICK) begin
                        addr_next  = '0;
                        state_next = ST_READ;
                    end else if (known_req && in_range) begin
                        addr_next  = s_channel[ADDR_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (!is_tick || channel_enable[addr_reg]) begin
                    mem_cmd.rd_en = 1'b1;
                    state_next    = ST_MODIFY;
                end else if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_MODIFY: begin
                if (is_tick) begin
                    res_valid = 1'b1;
                    if (res_ready) begin
                        mem_cmd.wr_en = 1'b1;
                        if (addr_reg == LAST_ADDR) begin
                            state_next = ST_IDLE;
                        end else begin
                            addr_next  = addr_reg + ADDR_W'(1);
                            state_next = ST_READ;
                        end
                    end
                end else begin
                    mem_cmd.wr_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_addr = addr_reg;

endmodule

### rtl/led_blink_pattern_sequencer_top.sv
// Top level of the LED blink sequencer: enable register, output register.
// Depends on lbps_pkg, lbps_state_mem and lbps_ctrl.
//
// An item on the s_ channel is either a request that changes one channel's
// settings (steady pattern, one-shot pattern with start phase, colour,
// standby colour) or a tick. A request produces no result; the block reads,
// modifies and writes back the channel's entry before it accepts the next
// item. A tick walks channels 0 up to min(NUM_CHANNELS, 8)-1 in order: an
// enabled channel's entry is read from memory, then written back as its
// result goes to the output register, which waits while that register is
// full and m_ready is low; a disabled channel is skipped. No new item is
// accepted until the walk is done. Each enabled channel yields one item on
// the m_ channel, with m_last on the final enabled channel; a tick with no
// channel enabled yields no item. The state memory's read and write ports
// share one address; each enabled channel's entry is read and written back
// once. channel_enable is written through cfg_wr_en/cfg_wr_data and should
// change only while the block is idle. After reset each entry reads as
// patterns off, phase at the top bit and white colours, with no clearing pass.
module led_blink_pattern_sequencer_top #(
    parameter int NUM_CHANNELS = lbps_pkg::NUM_CHANNELS_DEF,
    parameter int PHASE_BITS   = lbps_pkg::PHASE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [2:0] s_channel,
    input  logic [2:0] s_pattern,
    input  logic [4:0] s_cycle,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_out_channel,
    output logic       m_lit,
    output logic [7:0] m_drive_red,
    output logic [7:0] m_drive_green,
    output logic [7:0] m_drive_blue,
    output logic       m_last
);
    import lbps_pkg::*;

    // Only the first eight channels can ever be addressed.
    localparam int CH_LIMIT = (NUM_CHANNELS < CH_MAX) ? NUM_CHANNELS : CH_MAX;
    localparam int ADDR_W   = (CH_LIMIT > 1) ? $clog2(CH_LIMIT) : 1;
    localparam int WORD_W   = 2 * COLOUR_W + PHASE_BITS + 2 * PAT_W;

    localparam logic [PHASE_BITS-1:0] PHASE_TOP = PHASE_BITS'(1) << (PHASE_BITS - 1);
    // Entry layout, msb first: steady, one-shot, phase, colour, standby.
    localparam logic [WORD_W-1:0] RESET_WORD =
        {3'd0, 3'd0, PHASE_TOP, COLOUR_WHITE, COLOUR_WHITE};

    logic [7:0]        enable_reg;
    logic              m_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic              res_valid;
    logic              res_ready;
    mem_cmd_t          mem_cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic [WORD_W-1:0] mem_rd_data;

    // Hold the enable mask; take each write at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= ENABLE_RESET;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
        end
    end

    // Output register: take a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    lbps_state_mem #(
        .DEPTH      (CH_LIMIT),
        .ADDR_W     (ADDR_W),
        .WIDTH      (WORD_W),
        .RESET_WORD (RESET_WORD)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_cmd (mem_cmd),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    lbps_ctrl #(
        .CH_LIMIT   (CH_LIMIT),
        .ADDR_W     (ADDR_W),
        .PHASE_BITS (PHASE_BITS),
        .WORD_W     (WORD_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .channel_enable (enable_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_channel      (s_channel),
        .s_pattern      (s_pattern),
        .s_cycle        (s_cycle),
        .s_rgb          ({s_red, s_green, s_blue}),
        .mem_cmd        (mem_cmd),
        .mem_addr       (mem_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_data    (mem_rd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_channel = out_reg.channel;
    assign m_lit         = out_reg.lit;
    assign m_drive_red   = out_reg.red;
    assign m_drive_green = out_reg.green;
    assign m_drive_blue  = out_reg.blue;
    assign m_last        = out_reg.last;

endmodule

### rtl/lbps_checker.sv
// Port-level checks of the LED blink sequencer, bound to the top level.
// Depends on led_blink_pattern_sequencer_top_macros.svh.
`include "led_blink_pattern_sequencer_top_macros.svh"

module lbps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_out_channel,
    input logic       m_lit,
    input logic [7:0] m_drive_red,
    input logic [7:0] m_drive_green,
    input logic [7:0] m_drive_blue,
    input logic       m_last
);

    `LBPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_channel) && $stable(m_lit) && $stable(m_drive_red) && $stable(m_drive_green) && $stable(m_drive_blue) && $stable(m_last), "stalled result changed")
    `LBPS_ASSERT_NOW(a_unlit_dark, aclk, aresetn, m_valid && !m_lit, (m_drive_red == 8'd0) && (m_drive_green == 8'd0) && (m_drive_blue == 8'd0), "unlit item drives colour")
    `LBPS_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid, "result appeared right after accept")
    `LBPS_ASSERT_NEXT(a_channel_order, aclk, aresetn, m_valid && m_ready && !m_last, !m_valid || (m_out_channel > $past(m_out_channel)), "tick channels out of order")

endmodule

bind led_blink_pattern_sequencer_top lbps_checker u_lbps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_lit         (m_lit),
    .m_drive_red   (m_drive_red),
    .m_drive_green (m_drive_green),
    .m_drive_blue  (m_drive_blue),
    .m_last        (m_last)
);
